### design/ilha_pkg.sv
// Package for the implicit list heap allocator.
// Holds the beat types, action codes and tag helpers; depends on nothing.
package ilha_pkg;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] request_bytes;
    logic [15:0] block_addr;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] result_addr;
    logic        status;
  } out_beat_t;

  localparam logic [16:0] CHUNK_RESET = 17'd4096;
  localparam logic [16:0] MIN_BLOCK   = 17'd16;

  // Size field of a tag word, as a byte count that fits the 17-bit address space.
  function automatic logic [16:0] tag_size(input logic [31:0] w);
    tag_size = {w[16:3], 3'b000};
  endfunction

endpackage

### design/implicit_list_heap_allocator.sv
// Top level of the implicit list heap allocator.
// Uses ilha_pkg for types and helpers and ilha_mem for the heap words.
//
// A boundary-tag heap allocator over a single-port word memory with a registered read.
// One beat is taken at a time. Initialise makes four tag writes, then a chunk-sized growth
// with its merge. Allocate walks the block headers from the heap start; a block that fits
// is then split, while otherwise the heap is grown, merged and split. Free walks the same
// way until it reaches the address, then clears the tags and merges with neighbours. The
// header walk over the single memory port sets the rate, so the time grows with the number
// of blocks in the heap.
// The result waits in an output register; a new beat is accepted once it is taken.
module implicit_list_heap_allocator #(
  parameter int HEAP_WORDS = 16384
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ilha_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ilha_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [16:0]         cfg_wdata
);

  localparam int AW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
  localparam longint CAP_L = (longint'(HEAP_WORDS) * 4 > 65536) ? 65536
                                                                 : longint'(HEAP_WORDS) * 4;
  localparam logic [17:0] CAP = 18'(CAP_L);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_INIT  = 14'b00000000000010,
    S_WRD   = 14'b00000000000100, // walk: issue header read
    S_WCHK  = 14'b00000000001000, // walk: inspect header
    S_GROW  = 14'b00000000010000,
    S_MRD   = 14'b00000000100000, // merge: read own header
    S_MRD2  = 14'b00000001000000, // merge: read previous footer
    S_MRD3  = 14'b00000010000000, // merge: read next header
    S_MDEC  = 14'b00000100000000,
    S_CRD   = 14'b00001000000000, // carve: read header
    S_CARVE = 14'b00010000000000,
    S_WSEQ  = 14'b00100000000000, // write out queued words
    S_FRD   = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state;
  logic [16:0] chunk;
  logic [16:0] brk;
  logic [16:0] first;
  logic [1:0]  act;
  logic [16:0] asize;
  logic [16:0] faddr;
  logic [16:0] p;
  logic [16:0] sz;
  logic [16:0] prev_sz;
  logic        prev_a;
  logic [17:0] ext;
  logic        after_merge_carve;
  logic [2:0]  wcnt;
  logic [2:0]  widx;
  logic [16:0] wq_addr [4];
  logic [31:0] wq_data [4];
  state_t      wret;
  ilha_pkg::out_beat_t res;

  logic          m_we;
  logic [AW-1:0] m_addr;
  logic [31:0]   m_wdata;
  logic [31:0]   m_rdata;

  ilha_mem #(.DEPTH(HEAP_WORDS), .AW(AW)) u_mem (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
  );

  // Effective chunk: down to whole words, up to an even word count, at least 8 bytes.
  logic [17:0] chunk_eff;
  always_comb begin
    chunk_eff = {1'b0, chunk[16:3], 3'b000} + (chunk[2] ? 18'd8 : 18'd0);
    if (chunk_eff < 18'd8) begin
      chunk_eff = 18'd8;
    end
  end

  // Request rounded up to whole double words with room for both tags.
  logic [16:0] req_round;
  assign req_round = 17'(in_data.request_bytes) + 17'd15;

  logic [16:0] rsize;
  logic        ralloc;
  assign rsize  = ilha_pkg::tag_size(m_rdata);
  assign ralloc = m_rdata[0];

  // Memory port: writes from the queue, reads elsewhere. Out-of-range writes are dropped.
  logic [16:0] rd_addr;
  logic        rd_en;
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = 17'd0;
    case (state)
      S_WRD:   rd_addr = p - 17'd4;
      S_MRD:   rd_addr = p - 17'd4;
      S_MRD2:  rd_addr = p - 17'd8;
      S_MRD3:  rd_addr = p + sz - 17'd4;
      S_CRD:   rd_addr = p - 17'd4;
      S_FRD:   rd_addr = faddr - 17'd4;
      default: rd_en = 1'b0;
    endcase
    m_we    = 1'b0;
    m_wdata = wq_data[widx[1:0]];
    if (state == S_WSEQ) begin
      m_addr = AW'(wq_addr[widx[1:0]][16:2]);
      m_we   = ({17'd0, wq_addr[widx[1:0]][16:2]} < 32'(HEAP_WORDS));
    end else begin
      m_addr = AW'(rd_addr[16:2]);
    end
  end

  // Reads are registered: a flag marks the data as arrived.
  logic rvalid;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);
  assign out_data  = res;

  logic [17:0] p_ext;
  assign p_ext = {1'b0, brk} + ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      chunk  <= ilha_pkg::CHUNK_RESET;
      brk    <= 17'd0;
      first  <= 17'd0;
      rvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        chunk <= cfg_wdata;
      end
      rvalid <= rd_en && !rvalid;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act   <= in_data.action;
            faddr <= {1'b0, in_data.block_addr};
            res.result_addr <= 16'd0;
            res.status <= (ilha_pkg::action_t'(in_data.action) == ilha_pkg::ACT_ALLOC) &&
                          (brk == 17'd0);
            asize <= (in_data.request_bytes < 16'd8) ? ilha_pkg::MIN_BLOCK
                   : {req_round[16:3], 3'b000};
            p     <= first;
            case (ilha_pkg::action_t'(in_data.action))
              ilha_pkg::ACT_INIT:  state <= S_INIT;
              ilha_pkg::ACT_ALLOC: state <= (brk == 17'd0) ? S_DONE : S_WRD;
              ilha_pkg::ACT_FREE:  state <= (brk == 17'd0) ? S_DONE : S_WRD;
              default:             state <= S_DONE;
            endcase
          end
        end
        S_INIT: begin
          wq_addr[0] <= 17'd0;  wq_data[0] <= 32'd0;
          wq_addr[1] <= 17'd4;  wq_data[1] <= 32'd9;
          wq_addr[2] <= 17'd8;  wq_data[2] <= 32'd9;
          wq_addr[3] <= 17'd12; wq_data[3] <= 32'd1;
          brk   <= 17'd16;
          first <= 17'd8;
          ext   <= chunk_eff;
          wcnt  <= 3'd4;
          widx  <= 3'd0;
          wret  <= S_GROW;
          state <= S_WSEQ;
        end
        S_WRD: begin
          if (p >= brk) begin
            if (act == 2'(ilha_pkg::ACT_FREE)) begin
              state <= S_DONE;
            end else begin
              ext   <= (18'(asize) > chunk_eff) ? 18'(asize) : chunk_eff;
              state <= S_GROW;
            end
          end else begin
            state <= S_WCHK;
          end
        end
        S_WCHK: begin
          if (rvalid) begin
            if (act == 2'(ilha_pkg::ACT_FREE)) begin
              if (rsize == 17'd0 || p > faddr) begin
                state <= S_DONE;
              end else if (p == faddr) begin
                if (p != first && ralloc) begin
                  sz         <= rsize;
                  wq_addr[0] <= p - 17'd4;      wq_data[0] <= {15'd0, rsize};
                  wq_addr[1] <= p + rsize - 17'd8; wq_data[1] <= {15'd0, rsize};
                  wcnt  <= 3'd2;
                  widx  <= 3'd0;
                  wret  <= S_MRD;
                  after_merge_carve <= 1'b0;
                  state <= S_WSEQ;
                end else begin
                  state <= S_DONE;
                end
              end else begin
                p     <= p + rsize;
                state <= S_WRD;
              end
            end else begin
              if (rsize == 17'd0) begin
                ext   <= (18'(asize) > chunk_eff) ? 18'(asize) : chunk_eff;
                state <= S_GROW;
              end else if (!ralloc && asize <= rsize) begin
                state <= S_CRD;
              end else begin
                p     <= p + rsize;
                state <= S_WRD;
              end
            end
          end
        end
        S_GROW: begin
          if (p_ext > CAP) begin
            res.status <= 1'b1;
            state      <= S_DONE;
          end else begin
            p          <= brk;
            brk        <= p_ext[16:0];
            wq_addr[0] <= brk - 17'd4;              wq_data[0] <= {14'd0, ext};
            wq_addr[1] <= brk + ext[16:0] - 17'd8;  wq_data[1] <= {14'd0, ext};
            wq_addr[2] <= brk + ext[16:0] - 17'd4;  wq_data[2] <= 32'd1;
            wcnt  <= 3'd3;
            widx  <= 3'd0;
            wret  <= S_MRD;
            after_merge_carve <= (act == 2'(ilha_pkg::ACT_ALLOC));
            state <= S_WSEQ;
          end
        end
        S_MRD: begin
          if (rvalid) begin
            sz    <= rsize;
            state <= S_MRD2;
          end
        end
        S_MRD2: begin
          if (rvalid) begin
            prev_sz <= rsize;
            prev_a  <= ralloc;
            state   <= S_MRD3;
          end
        end
        S_MRD3: begin
          if (rvalid) begin
            state <= S_MDEC;
            if (prev_a && ralloc) begin
              wcnt <= 3'd0;
            end else begin
              wcnt <= 3'd2;
              if (prev_a) begin
                wq_addr[0] <= p - 17'd4;              wq_data[0] <= {15'd0, sz + rsize};
                wq_addr[1] <= p + sz + rsize - 17'd8; wq_data[1] <= {15'd0, sz + rsize};
              end else begin
                p <= p - prev_sz;
                wq_addr[0] <= p - prev_sz - 17'd4;
                wq_addr[1] <= p + sz - 17'd8 + (ralloc ? 17'd0 : rsize);
                wq_data[0] <= {15'd0, sz + prev_sz + (ralloc ? 17'd0 : rsize)};
                wq_data[1] <= {15'd0, sz + prev_sz + (ralloc ? 17'd0 : rsize)};
              end
            end
          end
        end
        S_MDEC: begin
          widx  <= 3'd0;
          wret  <= after_merge_carve ? S_CRD : S_DONE;
          state <= (wcnt == 3'd0) ? (after_merge_carve ? S_CRD : S_DONE) : S_WSEQ;
        end
        S_CRD: begin
          if (rvalid) begin
            sz    <= rsize;
            state <= S_CARVE;
          end
        end
        S_CARVE: begin
          res.result_addr <= p[15:0];
          widx <= 3'd0;
          wret <= S_DONE;
          if (sz - asize >= ilha_pkg::MIN_BLOCK) begin
            wq_addr[0] <= p - 17'd4;          wq_data[0] <= {15'd0, asize | 17'd1};
            wq_addr[1] <= p + asize - 17'd8;  wq_data[1] <= {15'd0, asize | 17'd1};
            wq_addr[2] <= p + asize - 17'd4;  wq_data[2] <= {15'd0, sz - asize};
            wq_addr[3] <= p + sz - 17'd8;     wq_data[3] <= {15'd0, sz - asize};
            wcnt <= 3'd4;
          end else begin
            wq_addr[0] <= p - 17'd4;          wq_data[0] <= {15'd0, sz | 17'd1};
            wq_addr[1] <= p + sz - 17'd8;     wq_data[1] <= {15'd0, sz | 17'd1};
            wcnt <= 3'd2;
          end
          state <= S_WSEQ;
        end
        S_WSEQ: begin
          if (widx + 3'd1 >= wcnt) begin
            state <= wret;
          end else begin
            widx <= widx + 3'd1;
          end
        end
        S_FRD:   state <= S_DONE;
        S_DONE: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A result beat always comes from a held beat: the block is busy while it is shown.
  a_out_busy: assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("result shown while accepting");
  // The break never passes the heap capacity.
  a_brk_cap: assert property (@(posedge clk) disable iff (rst) {1'b0, brk} <= CAP)
    else $error("break beyond capacity");
  // Every result carries an 8-byte aligned address.
  a_align: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.result_addr[2:0] == 3'd0))
    else $error("misaligned address");
`endif

endmodule

### design/ilha_mem.sv
// Heap word memory for the implicit list heap allocator.
// Single port, registered read; depends on nothing.
module ilha_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### tb/sv/implicit_list_heap_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for implicit_list_heap_allocator.
// Depends on ilha_pkg and the block itself; it carries its own heap predictor.
module implicit_list_heap_allocator_tb;

  localparam int unsigned WORDS = 16384;
  localparam int unsigned CAP = (WORDS * 4 > 65536) ? 65536 : WORDS * 4;
  localparam longint CYCLE_LIMIT = 30_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ilha_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ilha_pkg::out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;

  implicit_list_heap_allocator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow heap and the allocator's bookkeeping, as the block should hold them.
  logic [31:0] heap_mem [WORDS];
  int unsigned brk_bytes = 0;
  int unsigned base_payload = 0;
  logic [16:0] chunk_reg = ilha_pkg::CHUNK_RESET;

  ilha_pkg::in_beat_t pending_beats[$];
  ilha_pkg::out_beat_t expected_results[$];
  int unsigned live_blocks[$];   // payload addresses currently granted
  int failures = 0;
  int accepted_beats = 0;
  int received_beats = 0;
  bit quiet_phase = 1'b0;        // no idling in the closing stretch
  bit long_hold_done = 1'b0;
  longint cycles = 0;

  function automatic logic [31:0] heap_rd(int unsigned a);
    int unsigned i;
    i = a >> 2;
    return (i < WORDS) ? heap_mem[i] : 32'd0;
  endfunction

  function automatic void heap_wr(int unsigned a, int unsigned v);
    int unsigned i;
    i = a >> 2;
    if (i < WORDS) heap_mem[i] = v;
  endfunction

  function automatic int unsigned blk_size(int unsigned p);
    return heap_rd(p - 4) & ~32'd7;
  endfunction

  function automatic bit blk_used(int unsigned p);
    logic [31:0] w;
    w = heap_rd(p - 4);
    return w[0];
  endfunction

  // Boundary-tag coalescing: the neighbours' tags decide which of the
  // four merge cases applies.
  function automatic int unsigned coalesce(int unsigned p);
    int unsigned sz, prev_sz, nsz;
    logic [31:0] prev_tag;
    bit prev_used, next_used;
    sz = blk_size(p);
    prev_tag = heap_rd(p - 8);
    prev_used = prev_tag[0];
    prev_sz = prev_tag & ~32'd7;
    next_used = blk_used(p + sz);
    nsz = blk_size(p + sz);
    if (prev_used && next_used) return p;
    if (!next_used) sz += nsz;
    if (!prev_used) begin
      sz += prev_sz;
      p -= prev_sz;
    end
    heap_wr(p - 4, sz);
    heap_wr(p + sz - 8, sz);
    return p;
  endfunction

  function automatic int unsigned raise_break(int unsigned bytes);
    int unsigned p;
    p = brk_bytes;
    if (p + bytes > CAP) return 0;
    brk_bytes = p + bytes;
    heap_wr(p - 4, bytes);
    heap_wr(p + bytes - 8, bytes);
    heap_wr(p + bytes - 4, 1);
    return coalesce(p);
  endfunction

  // Chunk is truncated to whole words, rounded up to an even word count,
  // and never below one minimal 8-byte step.
  function automatic int unsigned growth_step();
    int unsigned w;
    w = 32'(chunk_reg) >> 2;
    if (w & 1) w++;
    w *= 4;
    return (w < 8) ? 8 : w;
  endfunction

  function automatic int unsigned first_fit(int unsigned asize);
    int unsigned p, sz;
    p = base_payload;
    while (p < brk_bytes) begin
      sz = blk_size(p);
      if (sz == 0) break;
      if (!blk_used(p) && asize <= sz) return p;
      p += sz;
    end
    return 0;
  endfunction

  function automatic bit is_granted(int unsigned a);
    int unsigned p, sz;
    p = base_payload;
    while (p < brk_bytes) begin
      sz = blk_size(p);
      if (sz == 0 || p > a) break;
      if (p == a) return (p != base_payload) && blk_used(p);
      p += sz;
    end
    return 1'b0;
  endfunction

  // Works out the answer to one accepted beat and updates the shadow heap.
  function automatic ilha_pkg::out_beat_t heap_answer(ilha_pkg::in_beat_t b);
    ilha_pkg::out_beat_t r;
    int unsigned asize, p, ext, sz, rest, req, addr;
    r = '0;
    req = 32'(b.request_bytes);
    addr = 32'(b.block_addr);
    case (ilha_pkg::action_t'(b.action))
      ilha_pkg::ACT_INIT: begin
        brk_bytes = 16;
        heap_wr(0, 0);
        heap_wr(4, 9);
        heap_wr(8, 9);
        heap_wr(12, 1);
        base_payload = 8;
        if (raise_break(growth_step()) == 0) r.status = 1'b1;
      end
      ilha_pkg::ACT_ALLOC: begin
        if (brk_bytes == 0) begin
          r.status = 1'b1;
        end else begin
          asize = (req < 8) ? 16 : 8 * ((req + 15) / 8);
          p = first_fit(asize);
          if (p == 0) begin
            ext = growth_step();
            if (asize > ext) ext = asize;
            p = raise_break(ext);
          end
          if (p == 0) begin
            r.status = 1'b1;
          end else begin
            // Split only when the remainder can hold a minimal block.
            sz = blk_size(p);
            rest = sz - asize;
            if (rest >= 16) begin
              heap_wr(p - 4, asize | 1);
              heap_wr(p + asize - 8, asize | 1);
              heap_wr(p + asize - 4, rest);
              heap_wr(p + sz - 8, rest);
            end else begin
              heap_wr(p - 4, sz | 1);
              heap_wr(p + sz - 8, sz | 1);
            end
            r.result_addr = p[15:0];
            live_blocks.push_back(p);
          end
        end
      end
      ilha_pkg::ACT_FREE: begin
        // A free of anything but a granted block is quietly ignored.
        if (brk_bytes != 0 && is_granted(addr)) begin
          sz = blk_size(addr);
          heap_wr(addr - 4, sz);
          heap_wr(addr + sz - 8, sz);
          void'(coalesce(addr));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: presents queued beats, holds a stalled beat, and inserts
  // random gaps between beats.
  int send_gap = 0;
  always @(posedge clk) begin
    bit taken;
    bit next_valid;
    taken = in_valid && !in_stall;
    next_valid = in_valid && !taken;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (taken) begin
        expected_results.push_back(heap_answer(in_data));
        accepted_beats++;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_beats.size() > 0) begin
          in_data <= pending_beats.pop_front();
          next_valid = 1'b1;
          if (!quiet_phase && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 5);
        end
      end
      in_valid <= next_valid;
    end
  end

  // Monitor: checks each result beat against the oldest expectation and
  // drives the stall, including one long hold that lets the block back up.
  int stall_left = 0;
  always @(posedge clk) begin
    ilha_pkg::out_beat_t want;
    bit hold;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        received_beats++;
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: addr %0d status %0d",
                   $time, out_data.result_addr, out_data.status);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (want.result_addr !== out_data.result_addr)
            $display("%0t: result_addr expected %0d actual %0d",
                     $time, want.result_addr, out_data.result_addr);
          if (want.status !== out_data.status)
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_data.status);
          if (want !== out_data) failures++;
        end
      end
      hold = 1'b0;
      if (!long_hold_done && accepted_beats >= 200) begin
        long_hold_done = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        hold = 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 4);
        hold = 1'b1;
      end
      out_stall <= hold;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_beat(ilha_pkg::action_t act, int unsigned req, int unsigned addr);
    ilha_pkg::in_beat_t b;
    b.action = act;
    b.request_bytes = req[15:0];
    b.block_addr = addr[15:0];
    while (pending_beats.size() >= 4) @(posedge clk);
    pending_beats.push_back(b);
  endtask

  // Lets everything in flight drain; every beat answers, so an empty
  // expectation queue means the block has gone idle.
  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_chunk(int unsigned v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v[16:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    chunk_reg = v[16:0];
  endtask

  // Mostly well-formed allocate/free traffic on a bounded set of live
  // blocks, with some noise: bogus frees, unused actions, huge requests.
  task automatic random_traffic(int n);
    int unsigned pick, a;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        push_beat(ilha_pkg::ACT_FREE, $urandom, $urandom);
      end else if (pick < 11) begin
        push_beat(ilha_pkg::ACT_NONE, $urandom, $urandom);
      end else if (pick < 15) begin
        push_beat(ilha_pkg::ACT_ALLOC, $urandom, $urandom);
      end else if (pick < 55 && live_blocks.size() > 0 || live_blocks.size() > 40) begin
        a = $urandom_range(0, live_blocks.size() - 1);
        push_beat(ilha_pkg::ACT_FREE, $urandom, live_blocks[a]);
        live_blocks.delete(a);
      end else begin
        push_beat(ilha_pkg::ACT_ALLOC,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4000)
                                              : $urandom_range(0, 200), $urandom);
      end
    end
  endtask

  initial begin
    int unsigned settings[6] = '{8, 5, 65536, 65535, 1000, 4096};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: before any heap exists, then the field extremes.
    push_beat(ilha_pkg::ACT_ALLOC, 16, 0);
    push_beat(ilha_pkg::ACT_FREE, 0, 16'h0010);
    push_beat(ilha_pkg::ACT_NONE, 16'hFFFF, 16'hFFFF);
    push_beat(ilha_pkg::ACT_INIT, 0, 0);
    push_beat(ilha_pkg::ACT_ALLOC, 0, 0);
    push_beat(ilha_pkg::ACT_ALLOC, 7, 0);
    push_beat(ilha_pkg::ACT_ALLOC, 8, 0);
    push_beat(ilha_pkg::ACT_ALLOC, 4000, 0);
    push_beat(ilha_pkg::ACT_ALLOC, 16'hFFFF, 16'hFFFF);
    push_beat(ilha_pkg::ACT_FREE, 0, 8);
    push_beat(ilha_pkg::ACT_FREE, 0, 16'hFFFF);
    push_beat(ilha_pkg::ACT_FREE, 0, 0);
    push_beat(ilha_pkg::ACT_FREE, 0, 32);
    push_beat(ilha_pkg::ACT_FREE, 0, 16);
    push_beat(ilha_pkg::ACT_FREE, 0, 16);
    push_beat(ilha_pkg::ACT_ALLOC, 24, 0);
    push_beat(ilha_pkg::ACT_NONE, 0, 0);
    drain();
    live_blocks.delete();

    foreach (settings[s]) begin
      write_chunk(settings[s]);
      live_blocks.delete();
      push_beat(ilha_pkg::ACT_INIT, 0, 0);
      if (s == 5) quiet_phase = 1'b1;
      random_traffic(220);
    end

    drain();
    repeat (50) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
